### hdl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TTOB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TTOB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ttob_pkg.sv
package ttob_pkg;

  localparam int GLYPH_COUNT = 96;

  localparam logic [7:0] FIRST_CHAR   = 8'h20;
  localparam logic [7:0] LAST_CHAR    = 8'h7E;
  localparam logic [7:0] WIDE_LIMIT   = 8'd122;
  localparam logic [7:0] NARROW_LIMIT = 8'd66;
  localparam logic [9:0] NARROW_BASE  = 10'h11C;
  localparam logic [7:0] COL_STEP     = 8'd6;
  localparam logic [3:0] LAST_PAGE    = 4'd4;

  localparam logic [7:0] CMD_MODE      = 8'h22;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_WIDE_LINE = 8'h40;
  localparam logic [7:0] CMD_NARROW    = 8'h04;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] PAD_BYTE      = 8'h00;

  localparam logic [3:0] STEP_MODE      = 4'd0;
  localparam logic [3:0] STEP_PAGE      = 4'd1;
  localparam logic [3:0] STEP_LINE      = 4'd2;
  localparam logic [3:0] STEP_COL_LO    = 4'd3;
  localparam logic [3:0] STEP_COL_HI    = 4'd4;
  localparam logic [3:0] STEP_GLYPH0    = 4'd5;
  localparam logic [3:0] STEP_WIDE_LAST = 4'd9;
  localparam logic [3:0] STEP_PAD       = 4'd10;

  typedef enum logic {
    VARIANT_WIDE   = 1'b0,
    VARIANT_NARROW = 1'b1
  } variant_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic [3:0] page;
    variant_t   variant;
    logic [3:0] col_lo;
    logic [3:0] col_hi;
  } desc_t;

  // column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h08082a1c08, 40'h0000000000
  };

  function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] pos);
    logic [39:0] row;
    row = '0;
    if (32'(idx) < GLYPH_COUNT) begin
      row = GLYPH_ROM[idx];
    end
    case (pos)
      3'd0:    glyph_byte = row[39:32];
      3'd1:    glyph_byte = row[31:24];
      3'd2:    glyph_byte = row[23:16];
      3'd3:    glyph_byte = row[15:8];
      3'd4:    glyph_byte = row[7:0];
      default: glyph_byte = 8'h00;
    endcase
  endfunction

endpackage

### hdl/ttob_ifs.sv
interface ttob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       first_of_text;
  logic [2:0] start_page;
  logic [6:0] start_column;

  modport source (output valid, character, first_of_text, start_page, start_column,
                  input ready);
  modport sink   (input valid, character, first_of_text, start_page, start_column,
                  output ready);
endinterface

interface ttob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_run;

  modport source (output valid, out_byte, is_data, last_of_run, input ready);
  modport sink   (input valid, out_byte, is_data, last_of_run, output ready);
endinterface

### hdl/text_to_oled_byte_stream.sv
// An accepted character is written to the run queue, then its first byte is loaded into the output register.
// Throughput: 10 words per character in the wide layout, 11 in the narrow one, one word
//   per cycle from the output register unless out_ch.ready stalls it; dropped characters are not queued.
// The front keeps accepting until the QUEUE_DEPTH-entry run queue is full.
// Reset (rst_n low, synchronous): page, column, home and halt state to zero, wide layout.
module text_to_oled_byte_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  ttob_in_if.sink     in_ch,
  ttob_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import ttob_pkg::*;

  desc_t push_data;
  desc_t head;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;

  ttob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ttob_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  ttob_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### hdl/ttob_queue.sv
module ttob_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttob_pkg::desc_t push_data,
  output logic           full,
  input  logic           pop,
  output ttob_pkg::desc_t head,
  output logic           head_valid
);
  import ttob_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/ttob_front.sv
module ttob_front (
  input  logic            clk,
  input  logic            rst_n,
  ttob_in_if.sink         in_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  output logic            push,
  output ttob_pkg::desc_t push_data,
  input  logic            full
);
  import ttob_pkg::*;

  variant_t   variant_r;
  logic [7:0] col_r, col_nxt;
  logic [3:0] page_r, page_nxt;
  logic [6:0] home_r, home_nxt;
  logic       halted_r, halted_nxt;

  logic       accept;
  logic       printable;
  logic [7:0] col_eff, col_adv, limit;
  logic [3:0] page_eff, page_adv;
  logic [6:0] home_eff;
  logic       halt_eff;
  logic [9:0] addr;
  logic [7:0] glyph_idx;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    if (in_ch.first_of_text) begin
      col_eff  = {1'b0, in_ch.start_column};
      page_eff = {1'b0, in_ch.start_page};
      home_eff = in_ch.start_column;
      halt_eff = 1'b0;
    end else begin
      col_eff  = col_r;
      page_eff = page_r;
      home_eff = home_r;
      halt_eff = halted_r;
    end

    printable = in_ch.character inside {[FIRST_CHAR:LAST_CHAR]};
    push      = accept && !halt_eff && printable;
    glyph_idx = in_ch.character - FIRST_CHAR;

    col_adv  = col_eff + COL_STEP;
    page_adv = page_eff + 4'd1;
    limit    = (variant_r == VARIANT_NARROW) ? NARROW_LIMIT : WIDE_LIMIT;
    addr     = (variant_r == VARIANT_NARROW) ? NARROW_BASE + {2'b00, col_eff}
                                              : {2'b00, col_eff};

    push_data.glyph   = glyph_idx[6:0];
    push_data.page    = page_eff;
    push_data.variant = variant_r;
    push_data.col_lo  = addr[3:0];
    push_data.col_hi  = addr[7:4];

    col_nxt    = col_r;
    page_nxt   = page_r;
    home_nxt   = home_r;
    halted_nxt = halted_r;
    if (accept) begin
      col_nxt    = col_eff;
      page_nxt   = page_eff;
      home_nxt   = home_eff;
      halted_nxt = halt_eff;
      if (push) begin
        if (col_adv > limit) begin
          col_nxt  = {1'b0, home_eff};
          page_nxt = page_adv;
        end else begin
          col_nxt = col_adv;
        end
        halted_nxt = (page_nxt > LAST_PAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VARIANT_WIDE;
      col_r     <= '0;
      page_r    <= '0;
      home_r    <= '0;
      halted_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        variant_r <= variant_t'(cfg_wdata);
      end
      col_r    <= col_nxt;
      page_r   <= page_nxt;
      home_r   <= home_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

### hdl/ttob_back.sv
module ttob_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ttob_pkg::desc_t head,
  input  logic            head_valid,
  output logic            pop,
  ttob_out_if.source      out_ch
);
  import ttob_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       is_data_r;
  logic       last_r;

  logic       load;
  logic       last;
  logic [7:0] byte_sel;
  logic       data_sel;
  logic [3:0] glyph_pos;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.is_data     = is_data_r;
  assign out_ch.last_of_run = last_r;

  always_comb begin
    last      = (step_r == ((head.variant == VARIANT_NARROW) ? STEP_PAD : STEP_WIDE_LAST));
    load      = head_valid && (!out_valid_r || out_ch.ready);
    pop       = load && last;
    glyph_pos = step_r - STEP_GLYPH0;

    data_sel = 1'b0;
    case (step_r)
      STEP_MODE:   byte_sel = CMD_MODE;
      STEP_PAGE:   byte_sel = CMD_PAGE_BASE + {4'b0000, head.page};
      STEP_LINE:   byte_sel = (head.variant == VARIANT_NARROW) ? CMD_NARROW : CMD_WIDE_LINE;
      STEP_COL_LO: byte_sel = {4'b0000, head.col_lo};
      STEP_COL_HI: byte_sel = CMD_COL_HI | {4'b0000, head.col_hi};
      STEP_PAD: begin
        byte_sel = PAD_BYTE;
        data_sel = 1'b1;
      end
      default: begin
        byte_sel = glyph_byte(head.glyph, glyph_pos[2:0]);
        data_sel = 1'b1;
      end
    endcase

    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      step_nxt      = last ? STEP_MODE : step_r + 4'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_MODE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_sel;
      is_data_r <= data_sel;
      last_r    <= last;
    end
  end

endmodule

### hdl/ttob_checker.sv
`include "assert_macros.svh"

module ttob_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_data,
  input logic out_last
);

  // output register empties on reset
  `TTOB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "word valid after reset")

  `TTOB_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid,
    "word dropped while stalled")

  // every run ends on a data word
  `TTOB_ASSERT(a_last_is_data, clk, rst_n, out_valid && out_last |-> out_is_data,
    "run ends on a command word")

  // a run streams without gaps once started
  `TTOB_ASSERT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !out_last |=> out_valid,
    "gap inside a run")

endmodule

bind text_to_oled_byte_stream ttob_checker u_ttob_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_is_data (out_ch.is_data),
  .out_last    (out_ch.last_of_run)
);
